@@ sv/two_opt_tour_move_engine_top_macros.svh @@
// Assertion macros for the 2-opt tour move engine.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef TWO_OPT_TOUR_MOVE_ENGINE_TOP_MACROS_SVH
`define TWO_OPT_TOUR_MOVE_ENGINE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tsp2opt_pkg.sv @@
// Shared types and constants of the 2-opt tour move engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tsp2opt_pkg;

    localparam int MAX_CITIES = 64;
    localparam int CITY_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DELTA_W    = 27;
    localparam int ACC_W      = DELTA_W + 1;
    localparam int SQ_PAIRS   = COORD_BITS + FRAC_BITS + 1;
    localparam int V_W        = 2 * SQ_PAIRS;
    localparam int ROOT_W     = SQ_PAIRS;
    localparam int REM_W      = ROOT_W + 1;
    localparam int DIST_W     = ROOT_W + 1;
    localparam int ITER_W     = $clog2(SQ_PAIRS + 1);
    localparam int MIN_CITIES = 3;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 40;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        RD_A, RD_C, RD_P, RD_Q, RD_NOW, RD_RP
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_APP2, S_MV_RC, S_MV_CHK, S_D_RP, S_D_RQ, S_D_GO,
        S_D_WAIT, S_MV_DEC, S_W_CHK, S_W_WR, S_L1, S_L2, S_RD_TAKE, S_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DP_IDLE, DP_SQUARE, DP_SUM, DP_ROOT, DP_ROUND
    } dist_phase_t;

    typedef struct packed {
        logic    latch;
        logic    fail;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_b;
        logic    cap_d;
        logic    cap_p;
        logic    dist_start;
        logic    dist_acc;
        logic    set_delta;
        logic    app_first;
        logic    app_second;
        logic    walk_init;
        logic    walk_step;
        logic    link1;
        logic    link2;
        logic    rd_take;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    app_bad;
        logic    move_bad;
        logic    read_bad;
        logic    empty;
        logic    adjacent;
        logic    dist_done;
        logic    dist_last;
        logic    delta_neg;
        logic    walk_end;
        logic    out_free;
    } dp_status_t;

endpackage

@@ sv/two_opt_tour_move_engine_top.sv @@
// 2-opt tour move engine, one word in and one word out per item.
// A move on non-adjacent edges computes four distances in the square root unit and, when
// applied, then reverses the segment one city at a time before relinking.
// One item at a time: the next word is taken in the cycle after the result is loaded.
// Reset (aresetn low, synchronous) empties the tour and sets city_count to 64.
`timescale 1ns / 1ps
`include "two_opt_tour_move_engine_top_macros.svh"

module two_opt_tour_move_engine_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: action[2], city_a[6], city_c[6], x_coord[16], y_coord[16]
    input  logic [tsp2opt_pkg::IN_W-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // fields from bit 0: status[1], accepted[1], delta[27], tour_city[6]
    output logic [tsp2opt_pkg::OUT_W-1:0]        m_tdata,
    input  logic                                cfg_wen,
    input  logic [tsp2opt_pkg::COUNT_W-1:0]      cfg_wdata
);
    import tsp2opt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    tsp2opt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tsp2opt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    `TSP_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second word taken while busy")
    `TSP_ASSERT_SAME(a_fail_idle, m_tvalid && m_tdata[0], !m_tdata[1], "invalid item applied")
    `TSP_ASSERT_SAME(a_neg_move, m_tvalid && m_tdata[1], m_tdata[28], "applied move not negative")

endmodule

@@ sv/tsp2opt_dist.sv @@
// Euclidean distance unit: |p - q| rounded, 8 fractional bits.
// Restoring square root, one bit pair per cycle; uses tsp2opt_pkg.
`timescale 1ns / 1ps

module tsp2opt_dist (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [tsp2opt_pkg::COORD_BITS-1:0] px,
    input  logic [tsp2opt_pkg::COORD_BITS-1:0] py,
    input  logic [tsp2opt_pkg::COORD_BITS-1:0] qx,
    input  logic [tsp2opt_pkg::COORD_BITS-1:0] qy,
    output logic                              done,
    output logic [tsp2opt_pkg::DIST_W-1:0]     dist_val
);
    import tsp2opt_pkg::*;

    dist_phase_t               phase_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic [COORD_BITS-1:0]     dx_reg, dy_reg;
    logic [2*COORD_BITS-1:0]   sqx_reg, sqy_reg;
    logic [V_W-1:0]            v_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic                      done_reg;

    logic [REM_W+1:0]          rem_sh;
    logic [REM_W+1:0]          trial;
    logic                      take;
    logic [REM_W+1:0]          rem_diff;
    logic [2*COORD_BITS:0]     sum_sq;

    // One restoring step
    always_comb begin
        rem_sh   = {rem_reg, v_reg[V_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        take     = (rem_sh >= trial);
        rem_diff = take ? (rem_sh - trial) : rem_sh;
        sum_sq   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    // Control: phase and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (phase_reg == DP_ROUND);
            unique case (phase_reg)
                DP_IDLE:   if (start) phase_reg <= DP_SQUARE;
                DP_SQUARE: phase_reg <= DP_SUM;
                DP_SUM:    phase_reg <= DP_ROOT;
                DP_ROOT:   if (iter_reg == ITER_W'(1)) phase_reg <= DP_ROUND;
                DP_ROUND:  phase_reg <= DP_IDLE;
                default:   phase_reg <= DP_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            DP_IDLE: begin
                if (start) begin
                    dx_reg <= (px > qx) ? (px - qx) : (qx - px);
                    dy_reg <= (py > qy) ? (py - qy) : (qy - py);
                end
            end
            DP_SQUARE: begin
                sqx_reg <= dx_reg * dx_reg;
                sqy_reg <= dy_reg * dy_reg;
            end
            DP_SUM: begin
                v_reg    <= {1'b0, sum_sq, {(2*FRAC_BITS){1'b0}}};
                root_reg <= '0;
                rem_reg  <= '0;
                iter_reg <= ITER_W'(SQ_PAIRS);
            end
            DP_ROOT: begin
                v_reg    <= {v_reg[V_W-3:0], 2'b00};
                rem_reg  <= rem_diff[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], take};
                iter_reg <= iter_reg - ITER_W'(1);
            end
            DP_ROUND: begin
                dist_reg <= (rem_reg > {1'b0, root_reg}) ? ({1'b0, root_reg} + DIST_W'(1))
                                                         : {1'b0, root_reg};
            end
            default: ;
        endcase
    end

    assign done     = done_reg;
    assign dist_val = dist_reg;

endmodule

@@ sv/tsp2opt_ctrl.sv @@
// Controller of the 2-opt tour move engine: sequences append, move and read.
// Drives command words into the datapath; uses tsp2opt_pkg.
`timescale 1ns / 1ps

module tsp2opt_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  tsp2opt_pkg::dp_status_t st,
    output tsp2opt_pkg::ctrl_cmd_t  cmd
);
    import tsp2opt_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                unique case (st.action)
                    ACT_APPEND: begin
                        if (st.app_bad || st.empty) state_next = S_DONE;
                        else                        state_next = S_APP2;
                    end
                    ACT_MOVE: state_next = st.move_bad ? S_DONE : S_MV_RC;
                    ACT_READ: state_next = st.read_bad ? S_DONE : S_RD_TAKE;
                    default:  state_next = S_DONE;
                endcase
            end
            S_APP2:    state_next = S_DONE;
            S_MV_RC:   state_next = S_MV_CHK;
            S_MV_CHK:  state_next = st.adjacent ? S_DONE : S_D_RQ;
            S_D_RP:    state_next = S_D_RQ;
            S_D_RQ:    state_next = S_D_GO;
            S_D_GO:    state_next = S_D_WAIT;
            S_D_WAIT: begin
                if (st.dist_done) state_next = st.dist_last ? S_MV_DEC : S_D_RP;
            end
            S_MV_DEC:  state_next = st.delta_neg ? S_W_CHK : S_DONE;
            S_W_CHK:   state_next = st.walk_end ? S_L1 : S_W_WR;
            S_W_WR:    state_next = S_W_CHK;
            S_L1:      state_next = S_L2;
            S_L2:      state_next = S_DONE;
            S_RD_TAKE: state_next = S_DONE;
            S_DONE:    if (st.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_A;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            S_DECODE: begin
                unique case (st.action)
                    ACT_APPEND: begin
                        cmd.fail      = st.app_bad;
                        cmd.app_first = !st.app_bad;
                    end
                    ACT_MOVE: begin
                        cmd.fail   = st.move_bad;
                        cmd.rd_en  = !st.move_bad;
                        cmd.rd_sel = RD_A;
                    end
                    ACT_READ: begin
                        cmd.fail   = st.read_bad;
                        cmd.rd_en  = !st.read_bad;
                        cmd.rd_sel = RD_RP;
                    end
                    default: cmd.fail = 1'b1;
                endcase
            end
            S_APP2: cmd.app_second = 1'b1;
            S_MV_RC: begin
                cmd.cap_b  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_C;
            end
            S_MV_CHK: begin
                cmd.cap_d  = 1'b1;
                cmd.rd_en  = !st.adjacent;
                cmd.rd_sel = RD_P;
            end
            S_D_RP: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_P;
            end
            S_D_RQ: begin
                cmd.cap_p  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_Q;
            end
            S_D_GO:   cmd.dist_start = 1'b1;
            S_D_WAIT: cmd.dist_acc   = st.dist_done;
            S_MV_DEC: begin
                cmd.set_delta = 1'b1;
                cmd.walk_init = st.delta_neg;
            end
            S_W_CHK: begin
                cmd.rd_en  = !st.walk_end;
                cmd.rd_sel = RD_NOW;
            end
            S_W_WR:    cmd.walk_step = 1'b1;
            S_L1:      cmd.link1     = 1'b1;
            S_L2:      cmd.link2     = 1'b1;
            S_RD_TAKE: cmd.rd_take   = 1'b1;
            S_DONE:    cmd.out_load  = st.out_free;
            default: ;
        endcase
    end

endmodule

@@ sv/tsp2opt_dp.sv @@
// Datapath of the 2-opt tour move engine: tour tables, coordinates, result word.
// Instantiates tsp2opt_dist; uses tsp2opt_pkg.
`timescale 1ns / 1ps

module tsp2opt_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tsp2opt_pkg::IN_W-1:0]       s_tdata,
    input  logic                              cfg_wen,
    input  logic [tsp2opt_pkg::COUNT_W-1:0]    cfg_wdata,
    input  tsp2opt_pkg::ctrl_cmd_t            cmd,
    output tsp2opt_pkg::dp_status_t           st,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [tsp2opt_pkg::OUT_W-1:0]      m_tdata
);
    import tsp2opt_pkg::*;

    // Tour tables and coordinates
    logic [CITY_W-1:0]     succ_mem [MAX_CITIES];
    logic [CITY_W-1:0]     pred_mem [MAX_CITIES];
    logic [COORD_BITS-1:0] x_mem    [MAX_CITIES];
    logic [COORD_BITS-1:0] y_mem    [MAX_CITIES];
    logic [CITY_W-1:0]     succ_rd_reg, pred_rd_reg;
    logic [COORD_BITS-1:0] x_rd_reg, y_rd_reg;

    logic [COUNT_W-1:0]    city_count_reg, loaded_count_reg;
    logic [CITY_W-1:0]     first_reg, last_reg, rp_reg;
    logic [MAX_CITIES-1:0] flag_reg;

    action_t               action_reg;
    logic [CITY_W-1:0]     a_reg, c_reg, b_reg, d_reg, now_reg;
    logic [COORD_BITS-1:0] x_in_reg, y_in_reg, px_reg, py_reg;
    logic [COUNT_W-1:0]    guard_reg;
    logic [1:0]            dk_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic                  res_status_reg, res_acc_reg;
    logic [DELTA_W-1:0]    res_delta_reg;
    logic [CITY_W-1:0]     res_city_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    logic [CITY_W-1:0]     rd_addr, p_city, q_city;
    logic                  succ_we, pred_we;
    logic [CITY_W-1:0]     succ_wa, succ_wd, pred_wa, pred_wd;
    logic                  empty, complete;
    logic [COUNT_W-1:0]    cfg_sat;
    logic                  dist_done;
    logic [DIST_W-1:0]     dist_val;
    logic signed [ACC_W-1:0] dist_ext;
    logic [DELTA_W-1:0]    delta_sat;

    tsp2opt_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.dist_start),
        .px       (px_reg),
        .py       (py_reg),
        .qx       (x_rd_reg),
        .qy       (y_rd_reg),
        .done     (dist_done),
        .dist_val (dist_val)
    );

    // Endpoints of the current distance term
    always_comb begin
        unique case (dk_reg)
            2'd0:    begin p_city = a_reg; q_city = c_reg; end
            2'd1:    begin p_city = b_reg; q_city = d_reg; end
            2'd2:    begin p_city = a_reg; q_city = b_reg; end
            default: begin p_city = c_reg; q_city = d_reg; end
        endcase
    end

    // Read address select
    always_comb begin
        unique case (cmd.rd_sel)
            RD_A:    rd_addr = a_reg;
            RD_C:    rd_addr = c_reg;
            RD_P:    rd_addr = p_city;
            RD_Q:    rd_addr = q_city;
            RD_NOW:  rd_addr = now_reg;
            RD_RP:   rd_addr = rp_reg;
            default: rd_addr = a_reg;
        endcase
    end

    // Link write ports
    always_comb begin
        succ_we = 1'b1;
        pred_we = 1'b1;
        succ_wa = a_reg;
        succ_wd = c_reg;
        pred_wa = c_reg;
        pred_wd = a_reg;
        priority if (cmd.app_first) begin
            succ_wa = empty ? a_reg : last_reg;
            succ_wd = a_reg;
            pred_wa = a_reg;
            pred_wd = empty ? a_reg : last_reg;
        end else if (cmd.app_second) begin
            succ_wa = a_reg;
            succ_wd = first_reg;
            pred_wa = first_reg;
            pred_wd = a_reg;
        end else if (cmd.walk_step) begin
            succ_wa = now_reg;
            succ_wd = pred_rd_reg;
            pred_wa = now_reg;
            pred_wd = succ_rd_reg;
        end else if (cmd.link1) begin
            succ_wa = a_reg;
            succ_wd = c_reg;
            pred_wa = c_reg;
            pred_wd = a_reg;
        end else if (cmd.link2) begin
            succ_wa = b_reg;
            succ_wd = d_reg;
            pred_wa = d_reg;
            pred_wd = b_reg;
        end else begin
            succ_we = 1'b0;
            pred_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (succ_we) succ_mem[succ_wa] <= succ_wd;
    end

    always_ff @(posedge aclk) begin
        if (pred_we) pred_mem[pred_wa] <= pred_wd;
    end

    always_ff @(posedge aclk) begin
        if (cmd.app_first) begin
            x_mem[a_reg] <= x_in_reg;
            y_mem[a_reg] <= y_in_reg;
        end
    end

    // Registered reads
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            succ_rd_reg <= succ_mem[rd_addr];
            pred_rd_reg <= pred_mem[rd_addr];
            x_rd_reg    <= x_mem[rd_addr];
            y_rd_reg    <= y_mem[rd_addr];
        end
    end

    // Clamp written city count to the legal range
    always_comb begin
        priority if (cfg_wdata < COUNT_W'(MIN_CITIES)) cfg_sat = COUNT_W'(MIN_CITIES);
        else if (cfg_wdata > COUNT_W'(MAX_CITIES))    cfg_sat = COUNT_W'(MAX_CITIES);
        else                                          cfg_sat = cfg_wdata;
    end

    // Tour bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg   <= COUNT_W'(MAX_CITIES);
            loaded_count_reg <= '0;
            first_reg        <= '0;
            last_reg         <= '0;
            rp_reg           <= '0;
            flag_reg         <= '0;
        end else if (cfg_wen) begin
            city_count_reg   <= cfg_sat;
            loaded_count_reg <= '0;
            first_reg        <= '0;
            last_reg         <= '0;
            rp_reg           <= '0;
            flag_reg         <= '0;
        end else begin
            if (cmd.app_first) begin
                flag_reg[a_reg]  <= 1'b1;
                last_reg         <= a_reg;
                loaded_count_reg <= loaded_count_reg + COUNT_W'(1);
                if (empty) first_reg <= a_reg;
            end
            if (cmd.rd_take) rp_reg <= succ_rd_reg;
        end
    end

    assign dist_ext = ACC_W'(signed'({1'b0, dist_val}));

    // Saturate the accumulated change to the result width
    always_comb begin
        if (acc_reg[ACC_W-1] != acc_reg[ACC_W-2]) begin
            delta_sat = {acc_reg[ACC_W-1], {(DELTA_W-1){!acc_reg[ACC_W-1]}}};
        end else begin
            delta_sat = acc_reg[DELTA_W-1:0];
        end
    end

    // Item fields, move working registers and result fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg     <= action_t'(s_tdata[1:0]);
            a_reg          <= s_tdata[7:2];
            c_reg          <= s_tdata[13:8];
            x_in_reg       <= s_tdata[29:14];
            y_in_reg       <= s_tdata[45:30];
            dk_reg         <= '0;
            acc_reg        <= '0;
            res_status_reg <= 1'b0;
            res_acc_reg    <= 1'b0;
            res_delta_reg  <= '0;
            res_city_reg   <= '0;
        end
        if (cmd.fail)  res_status_reg <= 1'b1;
        if (cmd.cap_b) b_reg <= succ_rd_reg;
        if (cmd.cap_d) d_reg <= succ_rd_reg;
        if (cmd.cap_p) begin
            px_reg <= x_rd_reg;
            py_reg <= y_rd_reg;
        end
        if (cmd.dist_acc) begin
            acc_reg <= dk_reg[1] ? (acc_reg - dist_ext) : (acc_reg + dist_ext);
            dk_reg  <= dk_reg + 2'd1;
        end
        if (cmd.set_delta) begin
            res_delta_reg <= delta_sat;
            res_acc_reg   <= acc_reg[ACC_W-1];
        end
        if (cmd.walk_init) begin
            now_reg   <= c_reg;
            guard_reg <= '0;
        end
        if (cmd.walk_step) begin
            now_reg   <= pred_rd_reg;
            guard_reg <= guard_reg + COUNT_W'(1);
        end
        if (cmd.rd_take) res_city_reg <= rp_reg;
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {5'b0, res_city_reg, res_delta_reg, res_acc_reg, res_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status back to the controller
    assign empty    = (loaded_count_reg == '0);
    assign complete = (loaded_count_reg == city_count_reg);

    always_comb begin
        st.action    = action_reg;
        st.app_bad   = ({1'b0, a_reg} >= city_count_reg) ||
                       (loaded_count_reg >= city_count_reg) || flag_reg[a_reg];
        st.move_bad  = !complete || ({1'b0, a_reg} >= city_count_reg) ||
                       ({1'b0, c_reg} >= city_count_reg) || (a_reg == c_reg);
        st.read_bad  = !complete;
        st.empty     = empty;
        st.adjacent  = (b_reg == c_reg) || (succ_rd_reg == a_reg);
        st.dist_done = dist_done;
        st.dist_last = (dk_reg == 2'd3);
        st.delta_neg = acc_reg[ACC_W-1];
        st.walk_end  = (now_reg == a_reg) || (guard_reg == COUNT_W'(MAX_CITIES));
        st.out_free  = !out_valid_reg || m_tready;
    end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the 2-opt tour move engine top level.
// Depends on tsp2opt_pkg and two_opt_tour_move_engine_top; a built-in tour
// model predicts each result word and a monitor compares it field by field.
`timescale 1ns / 1ps

module testbench;
    import tsp2opt_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;

    typedef struct packed {
        logic               status;
        logic               accepted;
        logic signed [26:0] delta;
        logic [5:0]         tour_city;
    } tour_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wen;
    logic [6:0]  cfg_wdata;

    // tour model state
    logic [5:0]  nxt_city [MAX_CITIES];
    logic [5:0]  prv_city [MAX_CITIES];
    logic [15:0] pos_x [MAX_CITIES];
    logic [15:0] pos_y [MAX_CITIES];
    bit          placed [MAX_CITIES];
    int          n_placed;
    int          head_city;
    int          tail_city;
    int          walk_ptr;
    int          n_cities;

    tour_result_t pending_results[$];
    int  fails;
    int  sent_words;
    bit  quiet;
    bit  stall_req;
    longint cycles = 0;

    two_opt_tour_move_engine_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("two_opt_tour_move_engine_top regression: fail");
            $finish;
        end
    end

    function automatic void clear_tour();
        for (int i = 0; i < MAX_CITIES; i++) begin
            nxt_city[i] = '0;
            prv_city[i] = '0;
            pos_x[i] = '0;
            pos_y[i] = '0;
            placed[i] = 1'b0;
        end
        n_placed = 0;
        head_city = 0;
        tail_city = 0;
        walk_ptr = 0;
    endfunction

    // round(sqrt(dx^2 + dy^2) * 256), bit-serial restoring root
    function automatic longint edge_length(int p, int q);
        longint unsigned dx, dy, v, root, rem, trial;
        dx = (pos_x[p] > pos_x[q]) ? pos_x[p] - pos_x[q] : pos_x[q] - pos_x[p];
        dy = (pos_y[p] > pos_y[q]) ? pos_y[p] - pos_y[q] : pos_y[q] - pos_y[p];
        v = (dx * dx + dy * dy) << 16;
        root = 0;
        rem = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        if (rem > root) root++;
        return longint'(root);
    endfunction

    // advance the tour model by one word and return the result it predicts
    function automatic tour_result_t predict_tour_result(action_t act, int a, int c,
                                                         logic [15:0] x, logic [15:0] y);
        tour_result_t r;
        int b, d, now, t;
        longint dl;
        r = '0;
        case (act)
            ACT_APPEND: begin
                if (a >= n_cities || n_placed >= n_cities || placed[a]) begin
                    r.status = 1'b1;
                end else begin
                    pos_x[a] = x;
                    pos_y[a] = y;
                    placed[a] = 1'b1;
                    if (n_placed == 0) begin
                        head_city = a;
                        nxt_city[a] = 6'(a);
                        prv_city[a] = 6'(a);
                    end else begin
                        nxt_city[tail_city] = 6'(a);
                        prv_city[a] = 6'(tail_city);
                        nxt_city[a] = 6'(head_city);
                        prv_city[head_city] = 6'(a);
                    end
                    tail_city = a;
                    n_placed++;
                end
            end
            ACT_MOVE: begin
                if (n_placed != n_cities || a >= n_cities || c >= n_cities || a == c) begin
                    r.status = 1'b1;
                end else begin
                    b = nxt_city[a];
                    d = nxt_city[c];
                    if (b != c && d != a) begin
                        dl = edge_length(a, c) + edge_length(b, d)
                           - edge_length(a, b) - edge_length(c, d);
                        if (dl < 0) begin
                            // reverse the segment from c back to b, then relink
                            now = c;
                            for (int g = 0; g < MAX_CITIES && now != a; g++) begin
                                t = nxt_city[now];
                                nxt_city[now] = prv_city[now];
                                prv_city[now] = 6'(t);
                                now = nxt_city[now];
                            end
                            nxt_city[a] = 6'(c);
                            prv_city[c] = 6'(a);
                            nxt_city[b] = 6'(d);
                            prv_city[d] = 6'(b);
                            r.accepted = 1'b1;
                        end
                        if (dl > 64'sd67108863) dl = 64'sd67108863;
                        if (dl < -64'sd67108864) dl = -64'sd67108864;
                        r.delta = dl[26:0];
                    end
                end
            end
            ACT_READ: begin
                if (n_placed != n_cities) begin
                    r.status = 1'b1;
                end else begin
                    r.tour_city = 6'(walk_ptr);
                    walk_ptr = nxt_city[walk_ptr];
                end
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    // offer one word, hold it until taken, then predict its result
    task automatic push_word(action_t act, int a, int c, logic [15:0] x, logic [15:0] y);
        logic [5:0] fa, fc;
        fa = 6'(a);
        fc = 6'(c);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, y, x, fc, fa, act};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_tour_result(act, fa, fc, x, y));
        sent_words++;
    endtask

    // wait until every result is back and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_city_count(int v);
        int sat;
        drain();
        cfg_wen <= 1'b1;
        cfg_wdata <= 7'(v);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sat = v & 7'h7f;
        if (sat < MIN_CITIES) sat = MIN_CITIES;
        if (sat > MAX_CITIES) sat = MAX_CITIES;
        n_cities = sat;
        clear_tour();
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // compare each result word against the oldest prediction
    task automatic check_word();
        tour_result_t got, want;
        got.status = m_tdata[0];
        got.accepted = m_tdata[1];
        got.delta = m_tdata[28:2];
        got.tour_city = m_tdata[34:29];
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, got %p", $time, got);
            fails++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fails++;
        end
        if (got.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0d actual %0d", $time, want.accepted,
                     got.accepted);
            fails++;
        end
        if (got.delta !== want.delta) begin
            $display("%0t: delta expected %0d actual %0d", $time, want.delta, got.delta);
            fails++;
        end
        if (got.tour_city !== want.tour_city) begin
            $display("%0t: tour_city expected %0d actual %0d", $time, want.tour_city,
                     got.tour_city);
            fails++;
        end
    endtask

    // result side: check, then stall at random or on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) check_word();
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                stall_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // corner requests on the reset tour and on tiny tours
    task automatic test_directed();
        push_word(ACT_MOVE, 0, 1, 0, 0);
        push_word(ACT_READ, 0, 0, 0, 0);
        push_word(ACT_NONE, 63, 63, 16'hffff, 16'hffff);
        set_city_count(0);
        push_word(ACT_APPEND, 5, 0, 1, 1);
        push_word(ACT_APPEND, 0, 0, 16'h0000, 16'h0000);
        push_word(ACT_APPEND, 0, 0, 7, 7);
        push_word(ACT_MOVE, 0, 1, 0, 0);
        push_word(ACT_APPEND, 1, 0, 16'hffff, 16'hffff);
        push_word(ACT_APPEND, 2, 0, 16'h0000, 16'hffff);
        push_word(ACT_APPEND, 1, 0, 3, 3);
        push_word(ACT_MOVE, 1, 1, 0, 0);
        push_word(ACT_MOVE, 0, 63, 0, 0);
        push_word(ACT_MOVE, 0, 1, 0, 0);
        push_word(ACT_MOVE, 0, 2, 0, 0);
        repeat (4) push_word(ACT_READ, 0, 0, 0, 0);
        // crossed square: order 0,2,1,3 gives an improving move
        set_city_count(4);
        push_word(ACT_APPEND, 0, 0, 0, 0);
        push_word(ACT_APPEND, 2, 0, 100, 100);
        push_word(ACT_APPEND, 1, 0, 100, 0);
        push_word(ACT_APPEND, 3, 0, 0, 100);
        push_word(ACT_MOVE, 0, 1, 0, 0);
        repeat (5) push_word(ACT_READ, 0, 0, 0, 0);
    endtask

    // one tour: load a shuffled ring, then moves, reads and noise
    task automatic run_tour(int count, int n_ops, bit partial);
        int order[$];
        int n_load, a, c, j, t;
        set_city_count(count);
        for (int i = 0; i < n_cities; i++) order.push_back(i);
        for (int i = n_cities - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        n_load = partial ? $urandom_range(1, n_cities - 1) : n_cities;
        for (int i = 0; i < n_load; i++) begin
            if ($urandom_range(0, 15) == 0) push_word(ACT_APPEND, $urandom_range(0, 63), 0,
                                                      rand_coord(), rand_coord());
            push_word(ACT_APPEND, order[i], 0, rand_coord(), rand_coord());
        end
        for (int k = 0; k < n_ops; k++) begin
            t = $urandom_range(0, 9);
            if (t < 7) begin
                a = $urandom_range(0, n_cities - 1);
                c = ($urandom_range(0, 15) == 0) ? a : $urandom_range(0, n_cities - 1);
                push_word(ACT_MOVE, a, c, 16'($urandom), 16'($urandom));
            end else if (t < 9) begin
                push_word(ACT_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                          16'($urandom), 16'($urandom));
            end else begin
                push_word(action_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                          $urandom_range(0, 63), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_random(int target);
        int phase;
        phase = 0;
        while (sent_words < target) begin
            phase++;
            if (phase % 8 == 0)
                run_tour(64, 40, 1'b0);
            else
                run_tour($urandom_range(4, 12), $urandom_range(10, 30),
                         $urandom_range(0, 5) == 0);
        end
    endtask

    // hold the result side off while words keep coming
    task automatic test_backpressure();
        run_tour(5, 0, 1'b0);
        stall_req = 1'b1;
        for (int k = 0; k < 20; k++) push_word(ACT_READ, 0, 0, 0, 0);
        for (int k = 0; k < 10; k++)
            push_word(ACT_MOVE, $urandom_range(0, 4), $urandom_range(0, 4), 0, 0);
        set_city_count(127);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        fails = 0;
        sent_words = 0;
        quiet = 1'b0;
        stall_req = 1'b0;
        n_cities = MAX_CITIES;
        clear_tour();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(1050);
        quiet = 1'b1;
        test_random(1250);
        drain();
        if (fails == 0) begin
            $display("two_opt_tour_move_engine_top regression: pass");
        end else begin
            $display("two_opt_tour_move_engine_top regression: fail");
        end
        $finish;
    end

endmodule

@@ two_opt_tour_move_engine_top.f @@
+incdir+sv
sv/tsp2opt_pkg.sv
sv/tsp2opt_dist.sv
sv/tsp2opt_ctrl.sv
sv/tsp2opt_dp.sv
sv/two_opt_tour_move_engine_top.sv
dv/testbench.sv
